>>> rtl/assert_macros.svh
// assert_macros.svh - assertion macros for the Butterworth mask generator.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// ante implies cons in the same cycle, checking paused while in reset
`define BFM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication failed");
// ante implies cons after the delay n, checking paused while in reset
`define BFM_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
        else $error("%m: delayed check failed");
// ante implies cons on the next cycle, checked in and out of reset
`define BFM_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define BFM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BFM_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons)
`define BFM_ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

>>> rtl/bfm_pkg.sv
// bfm_pkg.sv - types, widths and register codes of the Butterworth mask generator.
// No dependencies; used by bfm_div and axis_butterworth_mask_generator.
`timescale 1ns / 1ps

package bfm_pkg;

    // largest grid side; wider grid sizes saturate to it
    localparam int MAX_DIM    = 1024;

    localparam int DIM_W      = 11;
    localparam int COORD_W    = 10;
    localparam int CUT_W      = 8;
    localparam int ORD_W      = 2;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // power chain widths: dist^2, dist^4, dist^6 and cutoff^2, ^4, ^6
    localparam int SQ_W       = 2 * COORD_W;
    localparam int P4_W       = 4 * COORD_W;
    localparam int A_W        = 6 * COORD_W;
    localparam int C2_W       = 2 * CUT_W;
    localparam int C4_W       = 4 * CUT_W;
    localparam int B_W        = 6 * CUT_W;
    localparam int R2_W       = 2 * DIM_W;
    // divider: den = a + b, num = 255 * a, quotient one gain wide
    localparam int DEN_W      = A_W + 1;
    localparam int NUM_W      = A_W + GAIN_W;
    localparam int Q_BITS     = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RADIUS = 3'd4;

    localparam logic [DIM_W-1:0] RST_GRID_WIDTH    = 11'd512;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT   = 11'd512;
    localparam logic [CUT_W-1:0] RST_CUTOFF        = 8'd2;
    localparam logic [ORD_W-1:0] RST_ORDER         = 2'd1;
    localparam logic [DIM_W-1:0] RST_CENTER_RADIUS = 11'd5;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_in;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_x;
        logic [GAIN_W-1:0] gain_y;
    } t_out;

    // flags that ride along with a word through the divider
    typedef struct packed {
        logic pass;  // inside the all-pass disc
        logic zero;  // axis distance is zero
    } t_side;

endpackage

>>> rtl/bfm_div.sv
// bfm_div.sv - pipelined restoring divider, one quotient bit per stage.
// Depends on bfm_pkg for widths and the t_side flag struct.
`timescale 1ns / 1ps

module bfm_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  bfm_pkg::t_side           i_side,
    input  logic [bfm_pkg::NUM_W-1:0] i_num,
    input  logic [bfm_pkg::DEN_W-1:0] i_den,
    output logic                     o_valid,
    output bfm_pkg::t_side           o_side,
    output logic [bfm_pkg::Q_BITS-1:0] o_quot
);

    logic                        r_vld  [bfm_pkg::Q_BITS];
    bfm_pkg::t_side              r_side [bfm_pkg::Q_BITS];
    logic [bfm_pkg::NUM_W-1:0]   r_rem  [bfm_pkg::Q_BITS];
    logic [bfm_pkg::DEN_W-1:0]   r_den  [bfm_pkg::Q_BITS];
    logic [bfm_pkg::Q_BITS-1:0]  r_quot [bfm_pkg::Q_BITS];

    for (genvar k = 0; k < bfm_pkg::Q_BITS; k++) begin : g_stage
        // stage k settles quotient bit Q_BITS-1-k
        localparam int SH = bfm_pkg::Q_BITS - 1 - k;

        logic                       w_vld;
        bfm_pkg::t_side             w_side;
        logic [bfm_pkg::NUM_W-1:0]  w_rem;
        logic [bfm_pkg::DEN_W-1:0]  w_den;
        logic [bfm_pkg::Q_BITS-1:0] w_quot;
        logic [bfm_pkg::NUM_W-1:0]  w_dsh;
        logic [bfm_pkg::NUM_W-1:0]  n_rem;
        logic [bfm_pkg::Q_BITS-1:0] n_quot;

        if (k == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_side = i_side;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quot = '0;
        end else begin : g_body
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quot = r_quot[k-1];
        end

        assign w_dsh = bfm_pkg::NUM_W'(w_den) << SH;

        always_comb begin
            // subtract the shifted divisor where it fits
            if (w_rem >= w_dsh) begin
                n_rem  = w_rem - w_dsh;
                n_quot = {w_quot[bfm_pkg::Q_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_rem;
                n_quot = {w_quot[bfm_pkg::Q_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
            r_side[k] <= w_side;
            r_rem[k]  <= n_rem;
            r_den[k]  <= w_den;
            r_quot[k] <= n_quot;
        end
    end

    assign o_valid = r_vld[bfm_pkg::Q_BITS-1];
    assign o_side  = r_side[bfm_pkg::Q_BITS-1];
    assign o_quot  = r_quot[bfm_pkg::Q_BITS-1];

endmodule

>>> rtl/axis_butterworth_mask_generator.sv
// axis_butterworth_mask_generator.sv - top level: config registers, power chain, output.
// Depends on bfm_pkg, bfm_div and assert_macros.svh.
`timescale 1ns / 1ps
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ----------------------
//  item      in         start / busy         i_item   (col, row)
//  result    out        o_strobe, 1 cycle    o_result (gain_x, gain_y)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  One word is taken per clock while busy is low; each word then passes through
//  6 stages of distance, powers and sums, 8 divider stages and 1 output register.
//  Reset is synchronous and active low; busy is set in reset, is cleared once
//  reset is released, and stays low from then on.
//  The result side has no back-pressure: every strobe is taken as it comes.

module axis_butterworth_mask_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bfm_pkg::t_in                    i_item,
    output logic                            o_strobe,
    output bfm_pkg::t_out                   o_result,
    input  logic                            i_cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

`include "assert_macros.svh"

    localparam int LANES      = 2;   // lane 0: horizontal, lane 1: vertical
    localparam int FRONT_LAT  = 6;
    localparam int LATENCY    = FRONT_LAT + bfm_pkg::Q_BITS + 1;

    localparam logic [bfm_pkg::ORD_W-1:0] ORDER_FLAT  = 2'd0;
    localparam logic [bfm_pkg::ORD_W-1:0] ORDER_ONE   = 2'd1;
    localparam logic [bfm_pkg::ORD_W-1:0] ORDER_TWO   = 2'd2;
    localparam logic [bfm_pkg::ORD_W-1:0] ORDER_THREE = 2'd3;

    // ---------------------------------------------------------------- config
    logic [bfm_pkg::DIM_W-1:0]  r_grid_width,  n_grid_width;
    logic [bfm_pkg::DIM_W-1:0]  r_grid_height, n_grid_height;
    logic [bfm_pkg::CUT_W-1:0]  r_cutoff,      n_cutoff;
    logic [bfm_pkg::ORD_W-1:0]  r_order,       n_order;
    logic [bfm_pkg::DIM_W-1:0]  r_radius,      n_radius;
    logic                       r_busy;
    logic                       w_accept;

    always_comb begin
        n_grid_width  = r_grid_width;
        n_grid_height = r_grid_height;
        n_cutoff      = r_cutoff;
        n_order       = r_order;
        n_radius      = r_radius;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bfm_pkg::CFG_GRID_WIDTH:    n_grid_width  = i_cfg_data;
                bfm_pkg::CFG_GRID_HEIGHT:   n_grid_height = i_cfg_data;
                bfm_pkg::CFG_CUTOFF:        n_cutoff      = i_cfg_data[bfm_pkg::CUT_W-1:0];
                bfm_pkg::CFG_ORDER:         n_order       = i_cfg_data[bfm_pkg::ORD_W-1:0];
                bfm_pkg::CFG_CENTER_RADIUS: n_radius      = i_cfg_data;
                default: ;  // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= bfm_pkg::RST_GRID_WIDTH;
            r_grid_height <= bfm_pkg::RST_GRID_HEIGHT;
            r_cutoff      <= bfm_pkg::RST_CUTOFF;
            r_order       <= bfm_pkg::RST_ORDER;
            r_radius      <= bfm_pkg::RST_CENTER_RADIUS;
            r_busy        <= 1'b1;
        end else begin
            r_grid_width  <= n_grid_width;
            r_grid_height <= n_grid_height;
            r_cutoff      <= n_cutoff;
            r_order       <= n_order;
            r_radius      <= n_radius;
            r_busy        <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // saturate the grid side, then halve
    function automatic logic [bfm_pkg::COORD_W-1:0] center_of(
        input logic [bfm_pkg::DIM_W-1:0] dim
    );
        logic [bfm_pkg::DIM_W-1:0] sat;
        sat = (dim > bfm_pkg::DIM_W'(bfm_pkg::MAX_DIM)) ?
              bfm_pkg::DIM_W'(bfm_pkg::MAX_DIM) : dim;
        return sat[bfm_pkg::DIM_W-1:1];
    endfunction

    function automatic logic [bfm_pkg::COORD_W-1:0] abs_diff(
        input logic [bfm_pkg::COORD_W-1:0] p,
        input logic [bfm_pkg::COORD_W-1:0] q
    );
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    // ------------------------------------------------- stage 1: distances
    logic                           r_v1;
    logic [bfm_pkg::COORD_W-1:0]    r_dist1 [LANES];
    logic [bfm_pkg::COORD_W-1:0]    n_dist1 [LANES];

    always_comb begin
        n_dist1[0] = abs_diff(i_item.col, center_of(r_grid_width));
        n_dist1[1] = abs_diff(i_item.row, center_of(r_grid_height));
    end

    // ------------------------------------------------- stage 2: squares
    logic                           r_v2;
    logic [bfm_pkg::SQ_W-1:0]       r_sq2   [LANES];
    logic                           r_zero2 [LANES];
    logic [bfm_pkg::C2_W-1:0]       r_c2_2;
    logic [bfm_pkg::R2_W-1:0]       r_rr2;

    // ------------------------------------------------- stage 3: fourth powers, disc test
    logic                           r_v3;
    logic                           r_pass3;
    logic [bfm_pkg::SQ_W-1:0]       r_sq3   [LANES];
    logic [bfm_pkg::P4_W-1:0]       r_p4_3  [LANES];
    logic                           r_zero3 [LANES];
    logic [bfm_pkg::C2_W-1:0]       r_c2_3;
    logic [bfm_pkg::C4_W-1:0]       r_c4_3;

    // ------------------------------------------------- stage 4: sixth-power partial products
    logic                           r_v4;
    logic                           r_pass4;
    logic [bfm_pkg::SQ_W-1:0]       r_sq4   [LANES];
    logic [bfm_pkg::P4_W-1:0]       r_p4_4  [LANES];
    logic [bfm_pkg::P4_W-1:0]       r_pplo4 [LANES];
    logic [bfm_pkg::P4_W-1:0]       r_pphi4 [LANES];
    logic                           r_zero4 [LANES];
    logic [bfm_pkg::C2_W-1:0]       r_c2_4;
    logic [bfm_pkg::C4_W-1:0]       r_c4_4;
    logic [bfm_pkg::B_W-1:0]        r_c6_4;

    // ------------------------------------------------- stage 5: pick a and b by order
    logic                           r_v5;
    logic                           r_pass5;
    logic [bfm_pkg::A_W-1:0]        r_a5    [LANES];
    logic [bfm_pkg::A_W-1:0]        n_a5    [LANES];
    logic                           r_zero5 [LANES];
    logic [bfm_pkg::B_W-1:0]        r_b5;
    logic [bfm_pkg::B_W-1:0]        n_b5;

    // ------------------------------------------------- stage 6: numerator and divisor
    logic                           r_v6;
    logic [bfm_pkg::NUM_W-1:0]      r_num6  [LANES];
    logic [bfm_pkg::DEN_W-1:0]      r_den6  [LANES];
    bfm_pkg::t_side                 r_side6 [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            case (r_order)
                ORDER_FLAT:  n_a5[l] = bfm_pkg::A_W'(1);
                ORDER_ONE:   n_a5[l] = bfm_pkg::A_W'(r_sq4[l]);
                ORDER_TWO:   n_a5[l] = bfm_pkg::A_W'(r_p4_4[l]);
                ORDER_THREE: n_a5[l] = (bfm_pkg::A_W'(r_pphi4[l]) << bfm_pkg::SQ_W)
                                       + bfm_pkg::A_W'(r_pplo4[l]);
                default:     n_a5[l] = '0;
            endcase
        end
        case (r_order)
            ORDER_FLAT:  n_b5 = bfm_pkg::B_W'(1);
            ORDER_ONE:   n_b5 = bfm_pkg::B_W'(r_c2_4);
            ORDER_TWO:   n_b5 = bfm_pkg::B_W'(r_c4_4);
            ORDER_THREE: n_b5 = r_c6_4;
            default:     n_b5 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end

        for (int l = 0; l < LANES; l++) begin
            r_dist1[l] <= n_dist1[l];

            r_sq2[l]   <= bfm_pkg::SQ_W'(r_dist1[l]) * bfm_pkg::SQ_W'(r_dist1[l]);
            r_zero2[l] <= (r_dist1[l] == '0);

            r_sq3[l]   <= r_sq2[l];
            r_p4_3[l]  <= bfm_pkg::P4_W'(r_sq2[l]) * bfm_pkg::P4_W'(r_sq2[l]);
            r_zero3[l] <= r_zero2[l];

            // split dist^4 in halves so no distance product is wider than 20 x 20
            r_sq4[l]   <= r_sq3[l];
            r_p4_4[l]  <= r_p4_3[l];
            r_pplo4[l] <= bfm_pkg::P4_W'(r_p4_3[l][bfm_pkg::SQ_W-1:0])
                          * bfm_pkg::P4_W'(r_sq3[l]);
            r_pphi4[l] <= bfm_pkg::P4_W'(r_p4_3[l][bfm_pkg::P4_W-1:bfm_pkg::SQ_W])
                          * bfm_pkg::P4_W'(r_sq3[l]);
            r_zero4[l] <= r_zero3[l];

            r_a5[l]    <= n_a5[l];
            r_zero5[l] <= r_zero4[l];

            // 255 * a as (a << 8) - a
            r_num6[l]  <= (bfm_pkg::NUM_W'(r_a5[l]) << bfm_pkg::GAIN_W)
                          - bfm_pkg::NUM_W'(r_a5[l]);
            r_den6[l]  <= bfm_pkg::DEN_W'(r_a5[l]) + bfm_pkg::DEN_W'(r_b5);
            r_side6[l] <= '{pass: r_pass5, zero: r_zero5[l]};
        end

        r_c2_2  <= bfm_pkg::C2_W'(r_cutoff) * bfm_pkg::C2_W'(r_cutoff);
        r_rr2   <= bfm_pkg::R2_W'(r_radius) * bfm_pkg::R2_W'(r_radius);

        r_pass3 <= (bfm_pkg::R2_W'(r_sq2[0]) + bfm_pkg::R2_W'(r_sq2[1])) <= r_rr2;
        r_c2_3  <= r_c2_2;
        r_c4_3  <= bfm_pkg::C4_W'(r_c2_2) * bfm_pkg::C4_W'(r_c2_2);

        r_pass4 <= r_pass3;
        r_c2_4  <= r_c2_3;
        r_c4_4  <= r_c4_3;
        r_c6_4  <= bfm_pkg::B_W'(r_c4_3) * bfm_pkg::B_W'(r_c2_3);

        r_pass5 <= r_pass4;
        r_b5    <= n_b5;
    end

    // ------------------------------------------------- divider lanes
    logic                           w_div_vld  [LANES];
    bfm_pkg::t_side                 w_div_side [LANES];
    logic [bfm_pkg::Q_BITS-1:0]     w_div_quot [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        bfm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v6),
            .i_side  (r_side6[l]),
            .i_num   (r_num6[l]),
            .i_den   (r_den6[l]),
            .o_valid (w_div_vld[l]),
            .o_side  (w_div_side[l]),
            .o_quot  (w_div_quot[l])
        );
    end

    // ------------------------------------------------- output register
    logic                           r_strobe;
    bfm_pkg::t_out                  r_result;
    logic [bfm_pkg::GAIN_W-1:0]     n_gain [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (w_div_side[l].pass) begin
                n_gain[l] = '1;
            end else if (w_div_side[l].zero) begin
                n_gain[l] = '0;
            end else begin
                n_gain[l] = w_div_quot[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_div_vld[0] && w_div_vld[1];
        end
        r_result <= '{gain_x: n_gain[0], gain_y: n_gain[1]};
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ------------------------------------------------- assertions
    `BFM_ASSERT_DELAY(a_word_out, i_clk, i_rst_n, w_accept, LATENCY, o_strobe)
    `BFM_ASSERT_IMPL(a_word_src, i_clk, i_rst_n, o_strobe, $past(w_accept, LATENCY))
    `BFM_ASSERT_NEXT(a_rst_quiet, i_clk, !i_rst_n, !o_strobe && busy)

endmodule

>>> test/butterworth_gain_checker.sv
// butterworth_gain_checker.sv - watches the item, result and config channels of the
// Butterworth mask generator, predicts both axis gains and compares them.
// Depends on bfm_pkg for the word types, widths and register indexes.
`timescale 1ns / 1ps

module butterworth_gain_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  bfm_pkg::t_in                    i_item,
    input  logic                            i_strobe,
    input  bfm_pkg::t_out                   i_result,
    input  logic                            i_cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_pending,
    output int                              o_errors
);
    import bfm_pkg::*;

    logic [DIM_W-1:0] grid_w_q;
    logic [DIM_W-1:0] grid_h_q;
    logic [CUT_W-1:0] cutoff_q;
    logic [ORD_W-1:0] order_q;
    logic [DIM_W-1:0] radius_q;

    t_out expected_gains[$];
    t_out want;
    int   pending_count = 0;
    int   error_count = 0;

    assign o_pending = pending_count;
    assign o_errors  = error_count;

    // floor(255*a/(a+b)), a = span^(2n), b = cutoff^(2n), exact in 128 bits; 0 at zero span
    function automatic logic [GAIN_W-1:0] axis_gain(input logic [COORD_W-1:0] span);
        logic [127:0] a;
        logic [127:0] b;
        int k;
        a = 128'd1;
        b = 128'd1;
        for (k = 0; k < 2 * order_q; k++) begin
            a = a * span;
            b = b * cutoff_q;
        end
        if (span == '0) return '0;
        return GAIN_W'((a * 128'd255) / (a + b));
    endfunction

    function automatic t_out predict_gains(input t_in word);
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [31:0]        dist_sq;
        logic [31:0]        radius_sq;
        t_out               gains;
        // saturate oversized grids before halving
        w  = (grid_w_q > MAX_DIM) ? DIM_W'(MAX_DIM) : grid_w_q;
        h  = (grid_h_q > MAX_DIM) ? DIM_W'(MAX_DIM) : grid_h_q;
        cx = COORD_W'(w >> 1);
        cy = COORD_W'(h >> 1);
        dx = (word.col >= cx) ? word.col - cx : cx - word.col;
        dy = (word.row >= cy) ? word.row - cy : cy - word.row;
        dist_sq   = 32'(dx) * 32'(dx) + 32'(dy) * 32'(dy);
        radius_sq = 32'(radius_q) * 32'(radius_q);
        if (dist_sq > radius_sq) begin
            gains.gain_x = axis_gain(dx);
            gains.gain_y = axis_gain(dy);
        end else begin
            gains.gain_x = '1;
            gains.gain_y = '1;
        end
        return gains;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_w_q = RST_GRID_WIDTH;
            grid_h_q = RST_GRID_HEIGHT;
            cutoff_q = RST_CUTOFF;
            order_q  = RST_ORDER;
            radius_q = RST_CENTER_RADIUS;
            expected_gains.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_WIDTH:    grid_w_q = i_cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT:   grid_h_q = i_cfg_data[DIM_W-1:0];
                    CFG_CUTOFF:        cutoff_q = i_cfg_data[CUT_W-1:0];
                    CFG_ORDER:         order_q  = i_cfg_data[ORD_W-1:0];
                    CFG_CENTER_RADIUS: radius_q = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) expected_gains.push_back(predict_gains(i_item));
            if (i_strobe) begin
                if (expected_gains.size() == 0) begin
                    error_count++;
                    $error("result word with no coordinate pending: gain_x %0d gain_y %0d",
                           i_result.gain_x, i_result.gain_y);
                end else begin
                    want = expected_gains.pop_front();
                    if (i_result.gain_x !== want.gain_x) begin
                        error_count++;
                        $error("gain_x mismatch: expected %0d, actual %0d",
                               want.gain_x, i_result.gain_x);
                    end
                    if (i_result.gain_y !== want.gain_y) begin
                        error_count++;
                        $error("gain_y mismatch: expected %0d, actual %0d",
                               want.gain_y, i_result.gain_y);
                    end
                end
            end
        end
        pending_count = expected_gains.size();
    end

endmodule

>>> test/tb_axis_butterworth_mask_generator.sv
// tb_axis_butterworth_mask_generator.sv - stimulus and verdict for the Butterworth
// mask generator: directed corners, then randomized config phases with random gaps.
// Depends on bfm_pkg, axis_butterworth_mask_generator and butterworth_gain_checker.
`timescale 1ns / 1ps

module tb_axis_butterworth_mask_generator;
    import bfm_pkg::*;

    localparam int RANDOM_PHASES   = 15;
    localparam int WORDS_PER_PHASE = 100;
    localparam int GAP_MAX         = 16;
    localparam int DRAIN_CYCLES    = 40;
    localparam int DIM_TOP         = (1 << DIM_W) - 1;
    localparam int COORD_TOP       = (1 << COORD_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_item;
    logic                  o_strobe;
    t_out                  o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int                    pending_words;
    int                    error_count;
    logic [DIM_W-1:0]      cur_width;
    logic [DIM_W-1:0]      cur_height;
    logic                  burst_phase;

    axis_butterworth_mask_generator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    butterworth_gain_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_strobe   (o_strobe),
        .i_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending_words),
        .o_errors   (error_count)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // hold the write enable high across back-to-back writes; end_writes drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_GRID_WIDTH) cur_width = data;
        if (idx == CFG_GRID_HEIGHT) cur_height = data;
    endtask

    task automatic end_writes;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row,
                             input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= {col, row};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
    endtask

    function automatic int pick_gap;
        if (burst_phase || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // mostly inside the grid, the rest anywhere in the coordinate range
    function automatic logic [COORD_W-1:0] pick_coord(input logic [DIM_W-1:0] size);
        if (size >= 1 && size <= MAX_DIM && $urandom_range(0, 4) != 0)
            return COORD_W'($urandom_range(0, size - 1));
        return COORD_W'($urandom_range(0, COORD_TOP));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(MAX_DIM + 1, DIM_TOP));
            2:       return CFG_DATA_W'(MAX_DIM);
            3:       return CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom_range(2, MAX_DIM));
        endcase
    endfunction

    task automatic random_config;
        logic [ORD_W-1:0]      ord;
        logic [CFG_DATA_W-1:0] ord_data;
        logic [CFG_DATA_W-1:0] radius;
        ord      = ($urandom_range(0, 7) == 0) ? '0 : ORD_W'($urandom_range(1, 3));
        ord_data = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) << ORD_W : '0;
        ord_data = ord_data | ord;
        radius   = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, DIM_TOP))
                                               : CFG_DATA_W'($urandom_range(0, 40));
        write_reg(CFG_GRID_WIDTH, pick_dim());
        write_reg(CFG_GRID_HEIGHT, pick_dim());
        write_reg(CFG_CUTOFF, CFG_DATA_W'($urandom));
        write_reg(CFG_ORDER, ord_data);
        write_reg(CFG_CENTER_RADIUS, radius);
        // a write past the register list must change nothing
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_CENTER_RADIUS + 1, CFG_IDX_TOP)),
                      CFG_DATA_W'($urandom));
        end_writes();
    endtask

    initial begin
        int phase;
        int n;
        int idx;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        cur_width   = RST_GRID_WIDTH;
        cur_height  = RST_GRID_HEIGHT;
        burst_phase = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: centre at (256, 256), disc radius 5
        send_word(256, 256, 0);
        send_word(259, 260, 0);
        send_word(262, 256, 1);
        send_word(0, 0, 0);
        send_word(COORD_TOP, COORD_TOP, 2);
        send_word(COORD_TOP, 0, 0);
        send_word(0, COORD_TOP, 0);

        // zero cutoff; upper data bits must be masked off
        drain();
        write_reg(CFG_CUTOFF, 11'h700);
        end_writes();
        send_word(300, 256, 0);
        send_word(256, 300, 3);

        // order zero via masked write data
        drain();
        write_reg(CFG_ORDER, 11'h004);
        end_writes();
        send_word(300, 310, 0);
        send_word(256, 400, 0);

        // oversized width saturates, top order and cutoff, zero radius
        drain();
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(DIM_TOP));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(MAX_DIM));
        write_reg(CFG_ORDER, CFG_DATA_W'(3));
        write_reg(CFG_CUTOFF, CFG_DATA_W'(255));
        write_reg(CFG_CENTER_RADIUS, '0);
        end_writes();
        send_word(512, 512, 0);
        send_word(513, 512, 0);
        send_word(COORD_TOP, 0, 0);
        send_word(0, COORD_TOP, 0);

        // zero and minimum grid sizes, largest radius
        drain();
        write_reg(CFG_GRID_WIDTH, '0);
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(1));
        write_reg(CFG_ORDER, CFG_DATA_W'(2));
        write_reg(CFG_CUTOFF, CFG_DATA_W'(1));
        write_reg(CFG_CENTER_RADIUS, CFG_DATA_W'(DIM_TOP));
        end_writes();
        send_word(COORD_TOP, COORD_TOP, 0);
        send_word(0, 0, 0);

        // writes past the register list, then zero radius at the centre
        drain();
        write_reg(CFG_CENTER_RADIUS, '0);
        for (idx = CFG_CENTER_RADIUS + 1; idx <= CFG_IDX_TOP; idx++)
            write_reg(CFG_IDX_W'(idx), '1);
        end_writes();
        send_word(0, 0, 0);
        send_word(1, 0, 0);
        send_word(COORD_TOP, COORD_TOP, 1);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            random_config();
            burst_phase = (phase % 3 == 0);
            for (n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_coord(cur_width), pick_coord(cur_height), pick_gap());
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && pending_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
